// ===== rtl/core/rti_pkg.sv =====
// ----------------------------------------------------------------------------
// rti_pkg
// Shared widths, types and register codes for the ray/triangle intersection
// core. All geometry is signed fixed point with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
package rti_pkg;

  // Fixed-point format and operand widths
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned IN_W      = 32;
  localparam int unsigned DIFF_W    = IN_W + 1;         // vertex differences
  localparam int unsigned PROD_W    = 2 * DIFF_W;       // cross-product terms
  localparam int unsigned CROSS_W   = PROD_W + 1;       // cross-product result
  localparam int unsigned LO_W      = 34;               // low slice of a cross value
  localparam int unsigned HI_W      = CROSS_W - LO_W;   // signed high slice
  localparam int unsigned HIP_W     = DIFF_W + HI_W;    // high partial product
  localparam int unsigned LOP_W     = DIFF_W + LO_W + 1; // low partial product
  localparam int unsigned NUM_W     = 102;              // det and numerators
  localparam int unsigned MAG_W     = NUM_W - 1;        // normalized magnitudes
  localparam int unsigned Q_BITS    = 32;               // quotient bits per lane
  localparam int unsigned DIV_W     = MAG_W + Q_BITS;   // divider remainder
  localparam int unsigned TQ_W      = Q_BITS + 2;       // signed t before range check
  localparam int unsigned UV_W      = 17;               // barycentric output width
  localparam int unsigned LANES     = 3;
  localparam int unsigned NUM_CNT   = 4;

  // Smallest accepted |det|: one LSB at the scale of the det product
  localparam logic [MAG_W-1:0] EPS_MAG = MAG_W'(1) << (2 * FRAC_BITS);

  // Numerator slots
  localparam int unsigned NUM_DET = 0;
  localparam int unsigned NUM_U   = 1;
  localparam int unsigned NUM_V   = 2;
  localparam int unsigned NUM_T   = 3;

  // Divider lanes
  localparam int unsigned LANE_T = 0;
  localparam int unsigned LANE_U = 1;
  localparam int unsigned LANE_V = 2;

  // Cyclic neighbors for cross products
  localparam int unsigned NEXT1 [3] = '{1, 2, 0};
  localparam int unsigned NEXT2 [3] = '{2, 0, 1};

  // Configuration space
  localparam int unsigned REG_CNT = 8;
  localparam int unsigned ADDR_W  = $clog2(REG_CNT * 4);

  typedef enum logic [2:0] {
    REG_ORG_X  = 3'd0,
    REG_ORG_Y  = 3'd1,
    REG_ORG_Z  = 3'd2,
    REG_DIR_X  = 3'd3,
    REG_DIR_Y  = 3'd4,
    REG_DIR_Z  = 3'd5,
    REG_NEAR   = 3'd6,
    REG_FAR    = 3'd7
  } reg_idx_e;

  typedef logic signed [IN_W-1:0]    coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [CROSS_W-1:0] cross_t;
  typedef logic signed [HIP_W-1:0]   hip_t;
  typedef logic signed [LOP_W-1:0]   lop_t;
  typedef logic signed [NUM_W-1:0]   num_t;

  typedef struct packed {
    coord_t [2:0] origin;
    coord_t [2:0] dir;
    coord_t       near;
    coord_t       far;
  } ray_cfg_t;

  // One item in flight through the divider
  typedef struct packed {
    logic                         miss;
    logic                         t_neg;
    logic [MAG_W-1:0]             den;
    logic [LANES-1:0][DIV_W-1:0]  rem;
    logic [LANES-1:0][Q_BITS-1:0] quo;
  } div_t;

endpackage

// ===== rtl/core/rti_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rti_cfg_regs
// Ray register file behind a simple APB slave: origin, direction and the
// accepted distance range. Zero-wait-state reads and writes.
// ----------------------------------------------------------------------------
module rti_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rti_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output rti_pkg::ray_cfg_t          cfg_o
);
  import rti_pkg::*;

  ray_cfg_t cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Write on the access phase of a transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin <= '0;
      cfg_q.dir    <= '0;
      cfg_q.near   <= '0;
      cfg_q.far    <= 32'h7FFF_FFFF;
    end else if (wr_en) begin
      case (idx)
        REG_ORG_X: cfg_q.origin[0] <= pwdata;
        REG_ORG_Y: cfg_q.origin[1] <= pwdata;
        REG_ORG_Z: cfg_q.origin[2] <= pwdata;
        REG_DIR_X: cfg_q.dir[0]    <= pwdata;
        REG_DIR_Y: cfg_q.dir[1]    <= pwdata;
        REG_DIR_Z: cfg_q.dir[2]    <= pwdata;
        REG_NEAR:  cfg_q.near      <= pwdata;
        REG_FAR:   cfg_q.far       <= pwdata;
        default:   cfg_q           <= cfg_q;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_ORG_X: prdata = cfg_q.origin[0];
      REG_ORG_Y: prdata = cfg_q.origin[1];
      REG_ORG_Z: prdata = cfg_q.origin[2];
      REG_DIR_X: prdata = cfg_q.dir[0];
      REG_DIR_Y: prdata = cfg_q.dir[1];
      REG_DIR_Z: prdata = cfg_q.dir[2];
      REG_NEAR:  prdata = cfg_q.near;
      REG_FAR:   prdata = cfg_q.far;
      default:   prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/rti_geom.sv =====
// ----------------------------------------------------------------------------
// rti_geom
// Eight-stage front end: edges, cross products, split dot products, sign
// normalization and the det / barycentric rejection tests. Feeds the divider
// with the normalized det and the shifted numerators.
// ----------------------------------------------------------------------------
module rti_geom (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  rti_pkg::coord_t [8:0]   vert_i,
  input  logic                    cull_i,
  input  rti_pkg::ray_cfg_t       cfg_i,
  output logic                    valid_o,
  output rti_pkg::div_t           div_o
);
  import rti_pkg::*;

  localparam num_t EPS = num_t'({1'b0, EPS_MAG});

  logic [7:0] vld_q;
  logic [5:0] cull_q;

  diff_t  e1_d [3], e2_d [3], s_d [3];
  diff_t  s1_e1_q [3], s1_e2_q [3], s1_s_q [3];
  prod_t  s2_pa_q [3], s2_pb_q [3], s2_qa_q [3], s2_qb_q [3];
  diff_t  s2_e1_q [3], s2_e2_q [3], s2_s_q [3];
  cross_t s3_p_q [3], s3_q_q [3];
  diff_t  s3_e1_q [3], s3_e2_q [3], s3_s_q [3];
  diff_t  opa [NUM_CNT][3];
  cross_t opb [NUM_CNT][3];
  hip_t   s4_hi_q [NUM_CNT][3];
  lop_t   s4_lo_q [NUM_CNT][3];
  num_t   s5_prod_q [NUM_CNT][3];
  num_t   s6_num_q [NUM_CNT];

  num_t             det, tn, un_d, vn_d;
  logic             det_neg, miss7_d;
  logic [MAG_W-1:0] mag_d, tmag_d;
  logic [MAG_W-1:0] s7_mag_q, s7_tmag_q;
  num_t             s7_un_q, s7_vn_q;
  logic             s7_tneg_q, s7_miss_q;
  num_t             mag_s, uv_sum;
  div_t             s8_d, s8_q;

  // Edge and origin differences
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1_d[k] = {vert_i[3+k][IN_W-1], vert_i[3+k]} - {vert_i[k][IN_W-1], vert_i[k]};
      e2_d[k] = {vert_i[6+k][IN_W-1], vert_i[6+k]} - {vert_i[k][IN_W-1], vert_i[k]};
      s_d[k]  = {cfg_i.origin[k][IN_W-1], cfg_i.origin[k]} -
                {vert_i[k][IN_W-1], vert_i[k]};
    end
  end

  // Operand selection for the four dot products
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      opa[NUM_DET][k] = s3_e1_q[k];
      opa[NUM_U][k]   = s3_s_q[k];
      opa[NUM_V][k]   = {cfg_i.dir[k][IN_W-1], cfg_i.dir[k]};
      opa[NUM_T][k]   = s3_e2_q[k];
      opb[NUM_DET][k] = s3_p_q[k];
      opb[NUM_U][k]   = s3_p_q[k];
      opb[NUM_V][k]   = s3_q_q[k];
      opb[NUM_T][k]   = s3_q_q[k];
    end
  end

  // Sign normalization and the det test
  always_comb begin
    det     = s6_num_q[NUM_DET];
    tn      = s6_num_q[NUM_T];
    det_neg = det[NUM_W-1];
    mag_d   = det_neg ? MAG_W'(-det) : MAG_W'(det);
    un_d    = det_neg ? -s6_num_q[NUM_U] : s6_num_q[NUM_U];
    vn_d    = det_neg ? -s6_num_q[NUM_V] : s6_num_q[NUM_V];
    tmag_d  = tn[NUM_W-1] ? MAG_W'(-tn) : MAG_W'(tn);
    if (cull_q[5]) begin
      miss7_d = det < EPS;
    end else begin
      miss7_d = (det < EPS) && (det > -EPS);
    end
  end

  // Barycentric and t-overflow tests, divider setup
  always_comb begin
    mag_s  = num_t'({1'b0, s7_mag_q});
    uv_sum = s7_un_q + s7_vn_q;
    s8_d.miss = s7_miss_q || s7_un_q[NUM_W-1] || (s7_un_q > mag_s) ||
                s7_vn_q[NUM_W-1] || (uv_sum > mag_s) ||
                ((DIV_W'(s7_tmag_q) << FRAC_BITS) >= (DIV_W'(s7_mag_q) << Q_BITS));
    s8_d.t_neg        = s7_tneg_q;
    s8_d.den          = s7_mag_q;
    s8_d.rem[LANE_T]  = DIV_W'(s7_tmag_q) << FRAC_BITS;
    s8_d.rem[LANE_U]  = DIV_W'(s7_un_q[MAG_W-1:0]) << FRAC_BITS;
    s8_d.rem[LANE_V]  = DIV_W'(s7_vn_q[MAG_W-1:0]) << FRAC_BITS;
    s8_d.quo          = '0;
  end

  // Advance the payload stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cull_q <= {cull_q[4:0], cull_i};
      for (int k = 0; k < 3; k++) begin
        s1_e1_q[k] <= e1_d[k];
        s1_e2_q[k] <= e2_d[k];
        s1_s_q[k]  <= s_d[k];

        s2_pa_q[k] <= $signed(cfg_i.dir[NEXT1[k]]) * s1_e2_q[NEXT2[k]];
        s2_pb_q[k] <= $signed(cfg_i.dir[NEXT2[k]]) * s1_e2_q[NEXT1[k]];
        s2_qa_q[k] <= s1_s_q[NEXT1[k]] * s1_e1_q[NEXT2[k]];
        s2_qb_q[k] <= s1_s_q[NEXT2[k]] * s1_e1_q[NEXT1[k]];
        s2_e1_q[k] <= s1_e1_q[k];
        s2_e2_q[k] <= s1_e2_q[k];
        s2_s_q[k]  <= s1_s_q[k];

        s3_p_q[k]  <= cross_t'(s2_pa_q[k]) - cross_t'(s2_pb_q[k]);
        s3_q_q[k]  <= cross_t'(s2_qa_q[k]) - cross_t'(s2_qb_q[k]);
        s3_e1_q[k] <= s2_e1_q[k];
        s3_e2_q[k] <= s2_e2_q[k];
        s3_s_q[k]  <= s2_s_q[k];
      end
      for (int n = 0; n < NUM_CNT; n++) begin
        for (int k = 0; k < 3; k++) begin
          s4_hi_q[n][k]   <= opa[n][k] * $signed(opb[n][k][CROSS_W-1:LO_W]);
          s4_lo_q[n][k]   <= opa[n][k] * $signed({1'b0, opb[n][k][LO_W-1:0]});
          s5_prod_q[n][k] <= (num_t'(s4_hi_q[n][k]) <<< LO_W) + num_t'(s4_lo_q[n][k]);
        end
        s6_num_q[n] <= s5_prod_q[n][0] + s5_prod_q[n][1] + s5_prod_q[n][2];
      end
      s7_mag_q  <= mag_d;
      s7_un_q   <= un_d;
      s7_vn_q   <= vn_d;
      s7_tmag_q <= tmag_d;
      s7_tneg_q <= tn[NUM_W-1] ^ det_neg;
      s7_miss_q <= miss7_d;
      s8_q      <= s8_d;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[6:0], valid_i};
    end
  end

  assign valid_o = vld_q[7];
  assign div_o   = s8_q;

  // An item that survives the tests has a usable divisor
  a_den_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[7] && !s8_q.miss |-> s8_q.den >= EPS_MAG)
    else $error("divisor below epsilon on a surviving item");

endmodule

// ===== rtl/core/rti_div_pipe.sv =====
// ----------------------------------------------------------------------------
// rti_div_pipe
// Restoring divider, one quotient bit per stage for three lanes (t, u, v)
// that share the normalized det as divisor.
// ----------------------------------------------------------------------------
module rti_div_pipe (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  rti_pkg::div_t div_i,
  output logic          valid_o,
  output rti_pkg::div_t div_o
);
  import rti_pkg::*;

  logic [Q_BITS-1:0] vld_q;
  div_t              stg_q [Q_BITS];

  // One restoring step at a fixed divisor shift
  function automatic div_t div_step(div_t x, int unsigned sh);
    div_t             r;
    logic [DIV_W-1:0] dsh;
    logic [DIV_W:0]   diff;
    r   = x;
    dsh = DIV_W'(x.den) << sh;
    for (int l = 0; l < LANES; l++) begin
      diff       = {1'b0, x.rem[l]} - {1'b0, dsh};
      r.quo[l]   = {x.quo[l][Q_BITS-2:0], ~diff[DIV_W]};
      if (!diff[DIV_W]) begin
        r.rem[l] = diff[DIV_W-1:0];
      end
    end
    return r;
  endfunction

  // Advance the division stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stg_q[0] <= div_step(div_i, Q_BITS - 1);
      for (int g = 1; g < Q_BITS; g++) begin
        stg_q[g] <= div_step(stg_q[g-1], Q_BITS - 1 - g);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Q_BITS-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[Q_BITS-1];
  assign div_o   = stg_q[Q_BITS-1];

  // Final t remainder must be below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !div_o.miss |-> div_o.rem[LANE_T] < DIV_W'(div_o.den))
    else $error("t remainder not reduced below divisor");

  // u never exceeds one
  a_u_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !div_o.miss |-> div_o.quo[LANE_U] <= (Q_BITS'(1) << FRAC_BITS))
    else $error("u quotient above one");

endmodule

// ===== rtl/core/ray_triangle_intersect_core.sv =====
// ----------------------------------------------------------------------------
// ray_triangle_intersect_core
// Moller-Trumbore ray/triangle test for a stream of triangles against one
// ray held in APB registers.
//
// Load the ray origin, direction and the [range_near, range_far] distance
// window over APB while the core is idle. Triangles then enter on s_axis,
// one per transfer (nine Q16.16 vertex coordinates in tdata, cull flag in
// tuser), and each produces exactly one result transfer on m_axis: hit in
// tuser, hit_distance, bary_u and bary_v in tdata, all zero on a miss.
// One triangle is accepted per cycle while the output is not stalled. A result
// passes through 8 geometry stages (differences, cross products, split dot
// products, normalization, tests), 32 restoring divider stages producing
// one quotient bit each, one stage forming the signed t, and the output
// register. When the receiver holds tready low with a result waiting, all
// stages hold and s_axis_tready drops; nothing is lost or repeated.
// Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rti_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // Triangle input
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // vert_a_x, vert_a_y, vert_a_z, vert_b_x .. vert_c_z (32 bits each)
  input  logic [287:0]               s_axis_tdata,
  // cull_back
  input  logic [0:0]                 s_axis_tuser,
  // Result output
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // hit_distance[31:0], bary_u[48:32], bary_v[65:49], zero pad[71:66]
  output logic [71:0]                m_axis_tdata,
  // hit
  output logic [0:0]                 m_axis_tuser
);
  import rti_pkg::*;

  ray_cfg_t cfg;
  logic     en;
  logic     geo_vld, div_vld;
  div_t     geo_div, div_res;

  logic                   f1_vld_q, f1_miss_q;
  logic signed [TQ_W-1:0] f1_tq_q, tq_d;
  logic [UV_W-1:0]        f1_u_q, f1_v_q;
  logic [Q_BITS-1:0]      qm;
  logic                   rem_nz, hit_d;
  logic signed [TQ_W-1:0] near_x, far_x;

  logic              m_valid_q, m_hit_q;
  logic [IN_W-1:0]   m_dist_q;
  logic [UV_W-1:0]   m_u_q, m_v_q;

  // Global advance: output empty or being taken
  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  rti_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rti_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .vert_i  (s_axis_tdata),
    .cull_i  (s_axis_tuser[0]),
    .cfg_i   (cfg),
    .valid_o (geo_vld),
    .div_o   (geo_div)
  );

  rti_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (geo_vld),
    .div_i   (geo_div),
    .valid_o (div_vld),
    .div_o   (div_res)
  );

  // Form floored signed t from magnitude quotient and remainder
  always_comb begin
    qm     = div_res.quo[LANE_T];
    rem_nz = |div_res.rem[LANE_T];
    if (div_res.t_neg) begin
      tq_d = TQ_W'(0) - TQ_W'(qm) - TQ_W'(rem_nz);
    end else begin
      tq_d = TQ_W'(qm);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_tq_q   <= tq_d;
      f1_u_q    <= div_res.quo[LANE_U][UV_W-1:0];
      f1_v_q    <= div_res.quo[LANE_V][UV_W-1:0];
      f1_miss_q <= div_res.miss;
    end
  end

  // Range check against the distance window
  always_comb begin
    near_x = TQ_W'(cfg.near);
    far_x  = TQ_W'(cfg.far);
    hit_d  = !f1_miss_q && (f1_tq_q >= near_x) && (f1_tq_q <= far_x);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_hit_q  <= hit_d;
      m_dist_q <= hit_d ? f1_tq_q[IN_W-1:0] : '0;
      m_u_q    <= hit_d ? f1_u_q : '0;
      m_v_q    <= hit_d ? f1_v_q : '0;
    end
  end

  // Valid bits for the last two stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else if (en) begin
      f1_vld_q  <= div_vld;
      m_valid_q <= f1_vld_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_hit_q;
  assign m_axis_tdata  = {6'd0, m_v_q, m_u_q, m_dist_q};

  // A miss produces no hit and a zero distance in the result
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f1_vld_q && f1_miss_q && en |=> !m_hit_q && m_dist_q == '0)
    else $error("miss produced a nonzero result");

endmodule

// ===== tb/ray_triangle_intersect_checker.sv =====
// ----------------------------------------------------------------------------
// ray_triangle_intersect_checker
// Watches the register port and both streams of the intersection core. It
// keeps its own copy of the ray, works out the exact hit record for every
// accepted triangle with wide integer math, and compares each result
// transfer field by field against the oldest pending record.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rti_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic                       pready,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic [287:0]               s_axis_tdata,
  input  logic [0:0]                 s_axis_tuser,
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic [71:0]                m_axis_tdata,
  input  logic [0:0]                 m_axis_tuser,
  output int unsigned                fail_cnt_o,
  output int unsigned                pending_o,
  output int unsigned                hits_o,
  output int unsigned                checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rti_pkg::*;

  // Exact arithmetic: wide enough for every product and shifted numerator
  typedef logic signed [159:0] big_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] distance;
    logic [UV_W-1:0]    bary_u;
    logic [UV_W-1:0]    bary_v;
  } hit_rec_t;

  coord_t   org_q [3];
  coord_t   dir_q [3];
  coord_t   near_q;
  coord_t   far_q;
  hit_rec_t hit_queue [$];

  assign pending_o = hit_queue.size();

  // Moller-Trumbore at full precision against the current ray
  function automatic hit_rec_t trace_triangle(input logic [287:0] tri_data, input logic cull);
    big_t e1 [3], e2 [3], sv [3], dv [3], pv [3], qv [3];
    big_t det, mag, un, vn, tn, tsh, tq, uq, vq, eps, near_w, far_w;
    coord_t ca, cb, cc;
    trace_triangle = '0;
    for (int k = 0; k < 3; k++) begin
      ca = tri_data[32*k +: 32];
      cb = tri_data[32*(3+k) +: 32];
      cc = tri_data[32*(6+k) +: 32];
      e1[k] = big_t'(cb) - big_t'(ca);
      e2[k] = big_t'(cc) - big_t'(ca);
      sv[k] = big_t'(org_q[k]) - big_t'(ca);
      dv[k] = big_t'(dir_q[k]);
    end
    pv[0] = dv[1] * e2[2] - dv[2] * e2[1];
    pv[1] = dv[2] * e2[0] - dv[0] * e2[2];
    pv[2] = dv[0] * e2[1] - dv[1] * e2[0];
    det = e1[0] * pv[0] + e1[1] * pv[1] + e1[2] * pv[2];
    eps = big_t'(1) <<< (2 * FRAC_BITS);
    // Reject small or back-facing determinants
    mag = (det < 0) ? -det : det;
    if (cull ? (det < eps) : (mag < eps)) return trace_triangle;
    qv[0] = sv[1] * e1[2] - sv[2] * e1[1];
    qv[1] = sv[2] * e1[0] - sv[0] * e1[2];
    qv[2] = sv[0] * e1[1] - sv[1] * e1[0];
    un = sv[0] * pv[0] + sv[1] * pv[1] + sv[2] * pv[2];
    vn = dv[0] * qv[0] + dv[1] * qv[1] + dv[2] * qv[2];
    tn = e2[0] * qv[0] + e2[1] * qv[1] + e2[2] * qv[2];
    if (det < 0) begin
      det = -det;
      un  = -un;
      vn  = -vn;
      tn  = -tn;
    end
    if (un < 0 || un > det) return trace_triangle;
    if (vn < 0 || un + vn > det) return trace_triangle;
    // Floor division for t, then range check before truncation
    tsh = tn <<< FRAC_BITS;
    tq  = tsh / det;
    if (tsh < 0 && (tsh % det) != 0) tq = tq - 1;
    near_w = big_t'(near_q);
    far_w  = big_t'(far_q);
    if (tq < near_w || tq > far_w) return trace_triangle;
    uq = (un <<< FRAC_BITS) / det;
    vq = (vn <<< FRAC_BITS) / det;
    trace_triangle.hit      = 1'b1;
    trace_triangle.distance = tq[31:0];
    trace_triangle.bary_u   = uq[UV_W-1:0];
    trace_triangle.bary_v   = vq[UV_W-1:0];
  endfunction

  // Track register writes, predict on input transfers, compare on output transfers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    hit_rec_t exp_rec, got_rec;
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        org_q[k] <= '0;
        dir_q[k] <= '0;
      end
      near_q     <= '0;
      far_q      <= 32'sh7FFF_FFFF;
      fail_cnt_o <= 0;
      hits_o     <= 0;
      checked_o  <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[4:2]))
          REG_ORG_X: org_q[0] <= pwdata;
          REG_ORG_Y: org_q[1] <= pwdata;
          REG_ORG_Z: org_q[2] <= pwdata;
          REG_DIR_X: dir_q[0] <= pwdata;
          REG_DIR_Y: dir_q[1] <= pwdata;
          REG_DIR_Z: dir_q[2] <= pwdata;
          REG_NEAR:  near_q   <= pwdata;
          REG_FAR:   far_q    <= pwdata;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        hit_queue.push_back(trace_triangle(s_axis_tdata, s_axis_tuser[0]));
      if (m_axis_tvalid && m_axis_tready) begin
        got_rec.hit      = m_axis_tuser[0];
        got_rec.distance = m_axis_tdata[31:0];
        got_rec.bary_u   = m_axis_tdata[48:32];
        got_rec.bary_v   = m_axis_tdata[65:49];
        if (hit_queue.size() == 0) begin
          fail_cnt_o <= fail_cnt_o + 1;
          if (fail_cnt_o < 10)
            $display("%0t: unexpected result hit=%0b t=%h u=%h v=%h", $realtime,
                     got_rec.hit, got_rec.distance, got_rec.bary_u, got_rec.bary_v);
        end else begin
          exp_rec = hit_queue.pop_front();
          checked_o <= checked_o + 1;
          if (exp_rec.hit) hits_o <= hits_o + 1;
          if (exp_rec !== got_rec) begin
            fail_cnt_o <= fail_cnt_o + 1;
            if (fail_cnt_o < 10)
              $display("%0t: result %0d expected hit=%0b t=%h u=%h v=%h, got hit=%0b t=%h u=%h v=%h",
                       $realtime, checked_o, exp_rec.hit, exp_rec.distance, exp_rec.bary_u,
                       exp_rec.bary_v, got_rec.hit, got_rec.distance, got_rec.bary_u,
                       got_rec.bary_v);
          end
        end
      end
    end
  end

endmodule

// ===== tb/ray_triangle_intersect_core_tb.sv =====
// ----------------------------------------------------------------------------
// ray_triangle_intersect_core_tb
// Loads a series of rays over the register port and streams triangles at the
// core: directed corner cases first, then random triangles built to straddle
// the ray mixed with raw random coordinates, under random stalls on both
// streams. The checker instance predicts and compares every result.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rti_pkg::*;

  localparam longint ONE      = 65536;
  localparam int     WD_LIMIT = 20000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [287:0]        s_axis_tdata = '0;
  logic [0:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b1;
  logic [71:0]         m_axis_tdata;
  logic [0:0]          m_axis_tuser;

  int unsigned fail_cnt, pending, hits, checked;
  int unsigned tri_sent;
  bit          quiet;
  int          idle_cycles;
  longint      ray_org [3];
  longint      ray_dir [3];

  always #6 clk_i = ~clk_i;

  ray_triangle_intersect_core i_dut (.*);

  ray_triangle_intersect_checker i_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_cnt_o(fail_cnt), .pending_o(pending), .hits_o(hits), .checked_o(checked)
  );

  // Stall the result stream in random bursts
  initial begin
    forever begin
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      if (!quiet && $urandom_range(0, 1)) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("ray_triangle_intersect_core: mismatch");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_e idx, input longint value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value[31:0];
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx <= REG_ORG_Z) ray_org[idx] = value;
    else if (idx <= REG_DIR_Z) ray_dir[idx - REG_DIR_X] = value;
    // Leave the bus idle before the next transfer
    @(posedge clk_i);
  endtask

  // Drain the pipeline, then load a full ray
  task automatic load_ray(input longint ox, oy, oz, dx, dy, dz, rn, rf);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    write_reg(REG_ORG_X, ox);
    write_reg(REG_ORG_Y, oy);
    write_reg(REG_ORG_Z, oz);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_DIR_Z, dz);
    write_reg(REG_NEAR, rn);
    write_reg(REG_FAR, rf);
  endtask

  // Offer one triangle, with an occasional gap ahead of it
  task automatic send_tri(input longint ax, ay, az, bx, by, bz, cx, cy, cz, input bit cull);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {cz[31:0], cy[31:0], cx[31:0], bz[31:0], by[31:0], bx[31:0],
                      az[31:0], ay[31:0], ax[31:0]};
    s_axis_tuser  <= cull;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tri_sent++;
  endtask

  function automatic longint rand_coord();
    return longint'(signed'($urandom()));
  endfunction

  function automatic longint rand_span(input int half);
    return longint'($urandom_range(0, 2 * half)) - half;
  endfunction

  // Triangle placed so that a point on the ray lies near or inside it
  task automatic send_straddle();
    longint pt [3], e1 [3], e2 [3], av [3];
    int tt, u8, v8;
    tt = $urandom_range(0, 40);
    u8 = $urandom_range(0, 260);
    v8 = $urandom_range(0, 260 - ((u8 > 256) ? 256 : u8));
    for (int k = 0; k < 3; k++) begin
      pt[k] = ray_org[k] + tt * ray_dir[k] + (($urandom_range(0, 7) == 0) ? rand_span(4) : 0);
      e1[k] = rand_span(1 << 18);
      e2[k] = rand_span(1 << 18);
      av[k] = pt[k] - (u8 * e1[k] + v8 * e2[k]) / 256;
    end
    send_tri(av[0], av[1], av[2], av[0] + e1[0], av[1] + e1[1], av[2] + e1[2],
             av[0] + e2[0], av[1] + e2[1], av[2] + e2[2], $urandom_range(0, 1));
  endtask

  task automatic send_random_tri();
    send_tri(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 1));
  endtask

  // Mostly straddling triangles when guided, else raw random ones; some noise and degenerate ones
  task automatic random_batch(input int cnt, input bit guided);
    longint ax, ay, az;
    for (int n = 0; n < cnt; n++) begin
      case ($urandom_range(0, 9))
        0, 1: send_random_tri();
        2: begin
          ax = rand_span(1 << 20); ay = rand_span(1 << 20); az = rand_span(1 << 20);
          send_tri(ax, ay, az, ax, ay, az, ax + rand_span(int'(ONE)), ay, az,
                   $urandom_range(0, 1));
        end
        default: if (guided) send_straddle(); else send_random_tri();
      endcase
    end
  endtask

  localparam longint MAXC = 64'sh7FFF_FFFF;
  localparam longint MINC = -64'sh8000_0000;

  initial begin
    quiet    = 1'b0;
    tri_sent = 0;
    for (int k = 0; k < 3; k++) begin
      ray_org[k] = 0;
      ray_dir[k] = 0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset ray has no direction: everything misses
    send_tri(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, 1'b1);
    send_tri(MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC, MINC, 1'b0);
    send_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 1'b0);

    // Ray down +z from z = -10, t in [0, 100]
    load_ray(0, 0, -10 * ONE, 0, 0, ONE, 0, 100 * ONE);
    send_tri(-ONE, -ONE, 0, 0, ONE, 0, ONE, -ONE, 0, 1'b1);    // front face
    send_tri(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0, 1'b1);    // back face, culled
    send_tri(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0, 1'b0);    // back face, kept
    send_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 1'b0);             // hit at vertex a
    send_tri(-ONE, 0, 0, ONE, 0, 0, -ONE, ONE, 0, 1'b0);       // on edge ab
    send_tri(ONE, -ONE, 0, -ONE, ONE, 0, -ONE, -ONE, 0, 1'b0); // on edge ab, v=0
    send_tri(-ONE, 0, 0, 0, 0, 0, 0, -ONE, 0, 1'b0);           // hit at vertex b, u=1
    send_tri(ONE, ONE, 0, 2 * ONE, ONE, 0, ONE, 2 * ONE, 0, 1'b0);       // beside
    send_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 1'b0);                 // tiny det
    send_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);                 // degenerate
    send_tri(-ONE, -ONE, 0, ONE, -ONE, ONE, 0, ONE, 0, 1'b0);  // parallel edge in z
    send_tri(-ONE, -ONE, -20 * ONE, ONE, -ONE, -20 * ONE, 0, ONE, -20 * ONE, 1'b0);
    send_tri(-ONE, -ONE, 200 * ONE, ONE, -ONE, 200 * ONE, 0, ONE, 200 * ONE, 1'b0);
    send_tri(-ONE, -ONE, -10 * ONE, ONE, -ONE, -10 * ONE, 0, ONE, -10 * ONE, 1'b0);
    send_tri(3, -5, 7, -3 * ONE, 2, 5 * ONE, 2 * ONE, ONE, -ONE, 1'b0);  // slanted
    send_tri(MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MAXC, MINC, 1'b0);
    send_tri(MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC, MINC, MAXC, 1'b1);

    // Random rays, moderate sizes
    for (int ph = 0; ph < 4; ph++) begin
      load_ray(rand_span(1 << 24), rand_span(1 << 24), rand_span(1 << 24),
               rand_span(1 << 17), rand_span(1 << 17), rand_span(1 << 17),
               (ph == 0) ? 0 : rand_span(4 * int'(ONE)), (ph == 1) ? 20 * ONE : MAXC);
      random_batch(200, 1'b1);
    end

    // Extreme registers: widest range, large ray
    load_ray(MAXC, MINC, 0, MAXC, MINC, MAXC, MINC, MAXC);
    random_batch(120, 1'b0);
    load_ray(rand_span(1 << 22), 0, 0, 0, ONE, -ONE, MINC, MAXC);
    random_batch(120, 1'b1);

    // Empty range: near beyond far
    load_ray(0, 0, 0, ONE, ONE, ONE, 5 * ONE, 4 * ONE);
    random_batch(60, 1'b1);

    // Final stretch without any stalls
    load_ray(rand_span(1 << 20), rand_span(1 << 20), rand_span(1 << 20),
             rand_span(1 << 16), rand_span(1 << 16), rand_span(1 << 16), 0, MAXC);
    quiet = 1'b1;
    random_batch(150, 1'b1);
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Sent %0d triangles over 9 ray setups; %0d results checked, %0d of them hits.",
             tri_sent, checked, hits);
    if (fail_cnt == 0)
      $display("ray_triangle_intersect_core: match");
    else
      $display("ray_triangle_intersect_core: mismatch");
    $finish;
  end

endmodule

// ===== ray_triangle_intersect_core.f =====
rtl/core/rti_pkg.sv
rtl/core/rti_cfg_regs.sv
rtl/core/rti_geom.sv
rtl/core/rti_div_pipe.sv
rtl/core/ray_triangle_intersect_core.sv
tb/ray_triangle_intersect_checker.sv
tb/ray_triangle_intersect_core_tb.sv
